// ===== rtl/md5_pkg.sv =====
// Package with the shared types, round constants and helper functions of the MD5 block.
`timescale 1ns / 1ps

package md5_pkg;

  // Initial chaining words.
  localparam logic [31:0] MD5_IV0 = 32'h67452301;
  localparam logic [31:0] MD5_IV1 = 32'hefcdab89;
  localparam logic [31:0] MD5_IV2 = 32'h98badcfe;
  localparam logic [31:0] MD5_IV3 = 32'h10325476;

  localparam logic [7:0] MD5_PAD_BYTE = 8'h80;
  localparam logic [5:0] MD5_LEN_POS  = 6'd56;
  localparam logic [5:0] MD5_LAST_POS = 6'd63;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [1:0] {
    T_IDLE,
    T_COMP,
    T_PAD,
    T_DONE
  } top_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_LOAD,
    C_ROUND,
    C_FINAL
  } core_state_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  typedef struct packed {
    logic         done;
    logic [127:0] chain;
  } core_stat_t;

  // Message word index used by a given step.
  function automatic logic [3:0] md5_g(input logic [5:0] step);
    logic [3:0] i;
    logic [3:0] g;
    i = step[3:0];
    case (step[5:4])
      2'd0: g = i;
      2'd1: g = (i << 2) + i + 4'd1;
      2'd2: g = (i << 1) + i + 4'd5;
      2'd3: g = (i << 3) - i;
      default: g = i;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ===== rtl/md5_if.sv =====
// Valid/ready channel interfaces for the MD5 byte input and digest output.
`timescale 1ns / 1ps

interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
  modport mon    (input valid, ready, data_byte, byte_valid, end_of_message);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_half;
  logic        is_last;

  modport source (output valid, digest_half, is_last, input ready);
  modport sink   (input valid, digest_half, is_last, output ready);
  modport mon    (input valid, ready, digest_half, is_last);
endinterface

// ===== rtl/md5_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/md5_core.sv =====
// MD5 compression unit: chaining words and one step per cycle over the block RAM.
`timescale 1ns / 1ps

module md5_core (
  input  logic                clk,
  input  logic                rst_n,
  input  md5_pkg::core_ctrl_t ctrl,
  output md5_pkg::core_stat_t stat,
  output logic [3:0]          rd_addr,
  input  logic [31:0]         rd_data
);

  md5_pkg::core_state_t state_r, state_nxt;

  logic [31:0] chain_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r;

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  rot_amt;
  logic [63:0] rot64;
  logic [31:0] b_new;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      md5_pkg::C_IDLE:  if (ctrl.start) state_nxt = md5_pkg::C_LOAD;
      md5_pkg::C_LOAD:  state_nxt = md5_pkg::C_ROUND;
      md5_pkg::C_ROUND: if (rnd_r == 6'd63) state_nxt = md5_pkg::C_FINAL;
      md5_pkg::C_FINAL: state_nxt = md5_pkg::C_IDLE;
      default:          state_nxt = md5_pkg::C_IDLE;
    endcase
  end

  // Outputs: the read address runs one step ahead of the round that uses it.
  always_comb begin
    rd_addr    = 4'd0;
    stat.done  = 1'b0;
    stat.chain = {chain_r[0], chain_r[1], chain_r[2], chain_r[3]};
    case (state_r)
      md5_pkg::C_LOAD:  rd_addr = md5_pkg::md5_g(6'd0);
      md5_pkg::C_ROUND: rd_addr = md5_pkg::md5_g(rnd_r + 6'd1);
      md5_pkg::C_FINAL: stat.done = 1'b1;
      default:          rd_addr = 4'd0;
    endcase
  end

  // One MD5 step.
  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    sum     = a_r + f + rd_data + md5_pkg::MD5_K[rnd_r];
    rot_amt = md5_pkg::MD5_S[{rnd_r[5:4], rnd_r[1:0]}];
    rot64   = {sum, sum} << rot_amt;
    b_new   = b_r + rot64[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= md5_pkg::C_IDLE;
      chain_r[0] <= md5_pkg::MD5_IV0;
      chain_r[1] <= md5_pkg::MD5_IV1;
      chain_r[2] <= md5_pkg::MD5_IV2;
      chain_r[3] <= md5_pkg::MD5_IV3;
    end else begin
      state_r <= state_nxt;
      if (ctrl.init) begin
        chain_r[0] <= md5_pkg::MD5_IV0;
        chain_r[1] <= md5_pkg::MD5_IV1;
        chain_r[2] <= md5_pkg::MD5_IV2;
        chain_r[3] <= md5_pkg::MD5_IV3;
      end else if (state_r == md5_pkg::C_FINAL) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == md5_pkg::C_LOAD) begin
      a_r   <= chain_r[0];
      b_r   <= chain_r[1];
      c_r   <= chain_r[2];
      d_r   <= chain_r[3];
      rnd_r <= 6'd0;
    end else if (state_r == md5_pkg::C_ROUND) begin
      a_r   <= d_r;
      d_r   <= c_r;
      c_r   <= b_r;
      b_r   <= b_new;
      rnd_r <= rnd_r + 6'd1;
    end
  end

endmodule

// ===== rtl/md5_message_digest.sv =====
// Top level of the MD5 digest block: byte packing, padding, sequencing and digest output.
`timescale 1ns / 1ps

// Usage
// The input channel takes one request per message byte. A request with byte_valid set
// appends data_byte; a request with end_of_message set finalizes the message after the
// byte (if any) is appended. A request with neither flag changes nothing.
// Bytes are packed into little-endian words and written into a 16-word block RAM.
// Each full 64-byte block starts the compression unit, which runs one MD5 step per cycle
// out of that RAM; no request is taken while it runs. On end of message the padding
// bytes and the 64-bit length are pushed one per cycle while no compression runs (one or
// two compressions come along the way), then the digest is emitted as two 64-bit results,
// the first eight digest bytes first, is_last set on the second.
// The digest sits in its own output register, so the block returns to its reset state
// and takes the next message while the receiver stalls; a second digest waits until
// both halves of the first have been taken.
// Reset (rst_n low, synchronous) restores the initial chaining words and clears the
// byte position and length count; the block RAM contents are never read before written.

module md5_message_digest (
  input  logic             clk,
  input  logic             rst_n,
  md5_in_if.sink           in_ch,
  md5_out_if.source        out_ch
);

  md5_pkg::top_state_t state_r, state_nxt;

  logic [5:0]   pos_r;
  logic [63:0]  bit_cnt_r;
  logic [23:0]  acc_r;
  logic         pad_active_r;
  logic         pad_first_r;
  logic         len_phase_r;
  logic         len_done_r;
  logic [127:0] dig_r;
  logic         out_valid_r;
  logic         out_last_r;

  logic         in_accept;
  logic         out_accept;
  logic         push_en;
  logic [7:0]   push_data;
  logic [7:0]   pad_byte;
  logic         is_len;
  logic         wrap;
  logic         load_digest;

  logic         ram_we;
  logic [3:0]   ram_raddr;
  logic [31:0]  ram_rdata;

  md5_pkg::core_ctrl_t core_ctrl;
  md5_pkg::core_stat_t core_stat;

  md5_ram #(
    .WIDTH(32),
    .DEPTH(16)
  ) u_block_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos_r[5:2]),
    .wdata({push_data, acc_r}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  md5_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (core_ctrl),
    .stat   (core_stat),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Handshakes and the byte push path shared by message bytes and padding.
  always_comb begin
    in_ch.ready = (state_r == md5_pkg::T_IDLE);
    in_accept   = in_ch.valid && in_ch.ready;
    out_accept  = out_valid_r && out_ch.ready;

    // Length bytes start once the zero fill has reached position 56; the length is
    // sent low byte first, so the byte index is the low three bits of the position.
    is_len = !pad_first_r && ((pos_r == md5_pkg::MD5_LEN_POS) || len_phase_r);
    if (pad_first_r) begin
      pad_byte = md5_pkg::MD5_PAD_BYTE;
    end else if (is_len) begin
      pad_byte = bit_cnt_r[{pos_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end

    push_en   = 1'b0;
    push_data = pad_byte;
    case (state_r)
      md5_pkg::T_IDLE: begin
        push_en   = in_accept && in_ch.byte_valid;
        push_data = in_ch.data_byte;
      end
      md5_pkg::T_PAD: begin
        push_en = 1'b1;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase

    wrap   = push_en && (pos_r == md5_pkg::MD5_LAST_POS);
    ram_we = push_en && (pos_r[1:0] == 2'b11);

    // The finished digest moves to the output register only once the previous one
    // has fully drained.
    load_digest    = (state_r == md5_pkg::T_DONE) && !out_valid_r;
    core_ctrl.start = wrap;
    core_ctrl.init  = load_digest;

    out_ch.valid       = out_valid_r;
    out_ch.is_last     = out_last_r;
    out_ch.digest_half = out_last_r ? dig_r[63:0] : dig_r[127:64];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      md5_pkg::T_IDLE: begin
        if (wrap) begin
          state_nxt = md5_pkg::T_COMP;
        end else if (in_accept && in_ch.end_of_message) begin
          state_nxt = md5_pkg::T_PAD;
        end
      end
      md5_pkg::T_PAD: begin
        if (wrap) begin
          state_nxt = md5_pkg::T_COMP;
        end
      end
      md5_pkg::T_COMP: begin
        if (core_stat.done) begin
          if (!pad_active_r) begin
            state_nxt = md5_pkg::T_IDLE;
          end else if (len_done_r) begin
            state_nxt = md5_pkg::T_DONE;
          end else begin
            state_nxt = md5_pkg::T_PAD;
          end
        end
      end
      md5_pkg::T_DONE: begin
        if (load_digest) begin
          state_nxt = md5_pkg::T_IDLE;
        end
      end
      default: state_nxt = md5_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= md5_pkg::T_IDLE;
      pos_r        <= 6'd0;
      bit_cnt_r    <= 64'd0;
      pad_active_r <= 1'b0;
      pad_first_r  <= 1'b0;
      len_phase_r  <= 1'b0;
      len_done_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (push_en) begin
        pos_r <= pos_r + 6'd1;
      end

      if (state_r == md5_pkg::T_IDLE && in_accept) begin
        if (in_ch.byte_valid) begin
          bit_cnt_r <= bit_cnt_r + 64'd8;
        end
        if (in_ch.end_of_message) begin
          pad_active_r <= 1'b1;
          pad_first_r  <= 1'b1;
          len_phase_r  <= 1'b0;
          len_done_r   <= 1'b0;
        end
      end

      if (state_r == md5_pkg::T_PAD) begin
        pad_first_r <= 1'b0;
        if (is_len) begin
          len_phase_r <= 1'b1;
        end
        if (wrap && is_len) begin
          len_done_r <= 1'b1;
        end
      end

      // The message state returns to reset as the digest is captured.
      if (load_digest) begin
        out_valid_r  <= 1'b1;
        out_last_r   <= 1'b0;
        pos_r        <= 6'd0;
        bit_cnt_r    <= 64'd0;
        pad_active_r <= 1'b0;
        len_phase_r  <= 1'b0;
        len_done_r   <= 1'b0;
      end else if (out_accept) begin
        if (out_last_r) begin
          out_valid_r <= 1'b0;
        end else begin
          out_last_r <= 1'b1;
        end
      end
    end
  end

  // Partial word assembly; the fourth byte goes straight to the RAM with these three.
  always_ff @(posedge clk) begin
    if (push_en) begin
      case (pos_r[1:0])
        2'd0:    acc_r[7:0]   <= push_data;
        2'd1:    acc_r[15:8]  <= push_data;
        2'd2:    acc_r[23:16] <= push_data;
        default: acc_r        <= acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_digest) begin
      dig_r <= {md5_pkg::md5_swap32(core_stat.chain[127:96]),
                md5_pkg::md5_swap32(core_stat.chain[95:64]),
                md5_pkg::md5_swap32(core_stat.chain[63:32]),
                md5_pkg::md5_swap32(core_stat.chain[31:0])};
    end
  end

endmodule

// ===== rtl/md5_checker.sv =====
// Port-level assertions for the MD5 digest block and the bind that attaches them.
`timescale 1ns / 1ps

module md5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_half,
  input logic        out_is_last
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_digest_half) && $stable(out_is_last))
    else $error("md5: stalled digest half changed");

  // The first half is always followed directly by the second.
  a_half_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_is_last |=> out_valid && out_is_last)
    else $error("md5: second digest half missing");

  // No new digest can be ready right after the last half is taken.
  a_digest_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_last |=> !out_valid)
    else $error("md5: digest emitted without message processing");

  // Finalizing a message occupies the block for padding.
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_message |=> !in_ready)
    else $error("md5: request taken during padding");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_end_of_message(in_ch.end_of_message),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_digest_half  (out_ch.digest_half),
  .out_is_last      (out_ch.is_last)
);
